### rtl/rcu_pkg.sv
// ----------------------------------------------------------------------------
// rcu_pkg
// Shared types, operation codes and helpers for the rectangle clip unit.
// ----------------------------------------------------------------------------
package rcu_pkg;

	// default result coordinate range (signed bits)
	localparam int COORD_BITS_DEF = 32;

	// internal arithmetic width: position + size differences need 34 signed bits
	localparam int CALC_W = 34;

	typedef enum logic [2:0] {
		FN_NORMALIZE = 3'd0,
		FN_INSET     = 3'd1,
		FN_INTERSECT = 3'd2,
		FN_CONTAIN   = 3'd3,
		FN_POINT_IN  = 3'd4,
		FN_RECT_IN   = 3'd5,
		FN_EMPTY     = 3'd6
	} func_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_w;
		logic signed [31:0] a_h;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_w;
		logic signed [31:0] b_h;
	} item_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic [30:0]        r_w;
		logic [30:0]        r_h;
		logic               flag;
	} result_t;

	function automatic logic signed [CALC_W-1:0] smin(input logic signed [CALC_W-1:0] p,
		input logic signed [CALC_W-1:0] q);
		return (p < q) ? p : q;
	endfunction

	function automatic logic signed [CALC_W-1:0] smax(input logic signed [CALC_W-1:0] p,
		input logic signed [CALC_W-1:0] q);
		return (p > q) ? p : q;
	endfunction

	// clamp negative to zero
	function automatic logic signed [CALC_W-1:0] nneg(input logic signed [CALC_W-1:0] p);
		return p[CALC_W-1] ? '0 : p;
	endfunction

endpackage

### rtl/rcu_calc.sv
// ----------------------------------------------------------------------------
// rcu_calc
// Combinational rectangle arithmetic for one registered item, with saturation
// of the result to the signed COORD_BITS range.
// ----------------------------------------------------------------------------
module rcu_calc #(
	parameter int COORD_BITS = rcu_pkg::COORD_BITS_DEF
) (
	input  rcu_pkg::item_t   item,
	output rcu_pkg::result_t res
);

	localparam int CW = rcu_pkg::CALC_W;
	localparam logic signed [CW-1:0] CMAX = CW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [CW-1:0] CMIN = CW'(-(64'sd1 <<< (COORD_BITS - 1)));

	logic signed [CW-1:0] ax, ay, bx, by;
	logic signed [CW-1:0] naw, nah, nbw, nbh;
	logic signed [CW-1:0] a_r, a_b, b_r, b_b;
	logic signed [CW-1:0] in_l, in_t, in_r, in_b;
	logic signed [CW-1:0] ix_r, ix_b;
	logic signed [CW-1:0] iw, ih;
	logic signed [CW-1:0] rx, ry, rw, rh;
	logic signed [CW-1:0] rx_sat, ry_sat, rw_sat, rh_sat;
	logic                 flag;

	always_comb begin
		ax  = CW'(item.a_x);
		ay  = CW'(item.a_y);
		bx  = CW'(item.b_x);
		by  = CW'(item.b_y);
		naw = rcu_pkg::nneg(CW'(item.a_w));
		nah = rcu_pkg::nneg(CW'(item.a_h));
		nbw = rcu_pkg::nneg(CW'(item.b_w));
		nbh = rcu_pkg::nneg(CW'(item.b_h));

		// rectangle ends
		a_r = ax + naw;
		a_b = ay + nah;
		b_r = bx + nbw;
		b_b = by + nbh;

		// insets: left/top clipped to the size, right/bottom to what remains
		in_l = rcu_pkg::smin(rcu_pkg::nneg(bx), naw);
		in_t = rcu_pkg::smin(rcu_pkg::nneg(by), nah);
		in_r = rcu_pkg::smin(nbw, naw - in_l);
		in_b = rcu_pkg::smin(nbh, nah - in_t);

		ix_r = rcu_pkg::smin(a_r, b_r);
		ix_b = rcu_pkg::smin(a_b, b_b);

		iw = rcu_pkg::smin(nbw, naw);
		ih = rcu_pkg::smin(nbh, nah);

		rx   = '0;
		ry   = '0;
		rw   = '0;
		rh   = '0;
		flag = 1'b0;

		case (item.func)
			rcu_pkg::FN_NORMALIZE: begin
				rx = ax;
				ry = ay;
				rw = naw;
				rh = nah;
			end
			rcu_pkg::FN_INSET: begin
				rx = ax + in_l;
				ry = ay + in_t;
				rw = naw - in_l - in_r;
				rh = nah - in_t - in_b;
			end
			rcu_pkg::FN_INTERSECT: begin
				rx = rcu_pkg::smax(ax, bx);
				ry = rcu_pkg::smax(ay, by);
				rw = rcu_pkg::nneg(ix_r - rcu_pkg::smax(ax, bx));
				rh = rcu_pkg::nneg(ix_b - rcu_pkg::smax(ay, by));
			end
			rcu_pkg::FN_CONTAIN: begin
				// move B inside A, shrinking it to A's size first
				rx = rcu_pkg::smin(rcu_pkg::smax(bx, ax), a_r - iw);
				ry = rcu_pkg::smin(rcu_pkg::smax(by, ay), a_b - ih);
				rw = iw;
				rh = ih;
			end
			rcu_pkg::FN_POINT_IN: begin
				flag = (bx >= ax) && (by >= ay) && (bx < a_r) && (by < a_b);
			end
			rcu_pkg::FN_RECT_IN: begin
				flag = (bx >= ax) && (by >= ay) && (b_r <= a_r) && (b_b <= a_b);
			end
			rcu_pkg::FN_EMPTY: begin
				flag = item.a_w[31] || (item.a_w == '0) || item.a_h[31] || (item.a_h == '0);
			end
			default: begin
				flag = 1'b0;
			end
		endcase

		rx_sat = (rx < CMIN) ? CMIN : ((rx > CMAX) ? CMAX : rx);
		ry_sat = (ry < CMIN) ? CMIN : ((ry > CMAX) ? CMAX : ry);
		// sizes are never negative here
		rw_sat = (rw > CMAX) ? CMAX : rw;
		rh_sat = (rh > CMAX) ? CMAX : rh;

		res.r_x  = rx_sat[31:0];
		res.r_y  = ry_sat[31:0];
		res.r_w  = rw_sat[30:0];
		res.r_h  = rh_sat[30:0];
		res.flag = flag;
	end

endmodule

### rtl/rectangle_clip_unit.sv
// ----------------------------------------------------------------------------
// rectangle_clip_unit
// Axis-aligned rectangle normalize, inset, intersect, contain and test
// operations, one transaction per clock.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  command  | start / busy         | func, a_x, a_y, a_w, a_h, b_x..b_h
//  result   | done (one-cycle)     | r_x, r_y, r_w, r_h, flag
//
// A command is taken on any edge with start high; busy is always low, so one
// command per clock is sustained. The command is registered, then one pass of
// adders/comparators feeds the result register, which is loaded together with done.
// Reset clears the valid bits only; the payload registers are left alone.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
module rectangle_clip_unit #(
	parameter int COORD_BITS = rcu_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] a_h,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_w,
	input  logic signed [31:0] b_h,
	output logic               done,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic [30:0]        r_w,
	output logic [30:0]        r_h,
	output logic               flag
);

	logic             valid_s1;
	rcu_pkg::item_t   item_s1;
	rcu_pkg::result_t res_c;
	logic             done_q;
	rcu_pkg::result_t res_q;
	logic             accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{func: func, a_x: a_x, a_y: a_y, a_w: a_w, a_h: a_h,
				b_x: b_x, b_y: b_y, b_w: b_w, b_h: b_h};
		end
		if (valid_s1) begin
			res_q <= res_c;
		end
	end

	rcu_calc #(
		.COORD_BITS(COORD_BITS)
	) u_calc (
		.item(item_s1),
		.res (res_c)
	);

	assign done = done_q;
	assign r_x  = res_q.r_x;
	assign r_y  = res_q.r_y;
	assign r_w  = res_q.r_w;
	assign r_h  = res_q.r_h;
	assign flag = res_q.flag;

endmodule

### rtl/rcu_checker.sv
// ----------------------------------------------------------------------------
// rcu_checker
// Port-level checks for the rectangle clip unit, bound to the top level.
// ----------------------------------------------------------------------------
module rcu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [2:0]         func,
	input logic               done,
	input logic signed [31:0] r_x,
	input logic signed [31:0] r_y,
	input logic [30:0]        r_w,
	input logic [30:0]        r_h,
	input logic               flag
);

	// every accepted transaction produces a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted transaction without result");

	// no result appears without an earlier accepted transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without transaction");

	// test answers carry no rectangle
	a_flag_zero_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(done && flag) |-> (r_x == '0 && r_y == '0 && r_w == '0 && r_h == '0))
		else $error("flag set with nonzero rectangle");

	// rectangle operations never raise the flag
	a_rect_no_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && (func == rcu_pkg::FN_NORMALIZE ||
			func == rcu_pkg::FN_INSET || func == rcu_pkg::FN_INTERSECT ||
			func == rcu_pkg::FN_CONTAIN), 2)) |-> !flag)
		else $error("flag set by rectangle operation");

endmodule

bind rectangle_clip_unit rcu_checker u_rcu_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.func  (func),
	.done  (done),
	.r_x   (r_x),
	.r_y   (r_y),
	.r_w   (r_w),
	.r_h   (r_h),
	.flag  (flag)
);
